>>> design/scan_disk_request_scheduler_unit_assert.svh
// Assertion macros used by the scheduler top level.
`ifndef SCAN_DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define SCAN_DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SDRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdrs assertion failed");
// Next-cycle implication.
`define SDRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdrs assertion failed");
`else
`define SDRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/sdrs_pkg.sv
`default_nettype none
package sdrs_pkg;

	localparam int CYL_W    = 16;
	localparam int SEEK_W   = 17;
	localparam int TRAVEL_W = 18;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_RUN  = 1'b1;
	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	localparam logic [PADDR_W-3:0] REG_MAX_CYL   = '0;
	localparam logic [CYL_W-1:0]   MAX_CYL_RESET = '1;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic run_init;
		logic emit_empty;
		logic scan;
		logic serve;
		logic edge_move;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic scan_done;
		logic found;
		logic last;
	} sts_t;

endpackage
`default_nettype wire

>>> design/sdrs_regs.sv
`default_nettype none
module sdrs_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sdrs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [sdrs_pkg::PDATA_W-1:0]  pwdata,
	output logic      [sdrs_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output logic      [sdrs_pkg::CYL_W-1:0]    max_cyl
);

	logic [sdrs_pkg::CYL_W-1:0]     max_cyl_q;
	logic [sdrs_pkg::PADDR_W-3:0]   reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[sdrs_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (reg_idx == sdrs_pkg::REG_MAX_CYL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cyl_q <= sdrs_pkg::MAX_CYL_RESET;
		end else if (wr_en) begin
			max_cyl_q <= pwdata[sdrs_pkg::CYL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == sdrs_pkg::REG_MAX_CYL) begin
			prdata[sdrs_pkg::CYL_W-1:0] = max_cyl_q;
		end
	end

	assign max_cyl = max_cyl_q;

endmodule
`default_nettype wire

>>> design/sdrs_dp.sv
`default_nettype none
module sdrs_dp #(
	parameter int MAX_REQ = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sdrs_pkg::ctl_t                ctl,
	output sdrs_pkg::sts_t                     sts,
	input  wire logic [sdrs_pkg::CYL_W-1:0]    cylinder,
	input  wire logic                          direction,
	input  wire logic [sdrs_pkg::CYL_W-1:0]    max_cyl,
	output logic                               strobe,
	output logic      [sdrs_pkg::CYL_W-1:0]    served_cylinder,
	output logic      [sdrs_pkg::SEEK_W-1:0]   seek_total,
	output logic                               last_of_run,
	output logic                               queue_empty
);

	localparam int IW = $clog2(MAX_REQ);
	localparam int CW = $clog2(MAX_REQ + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQ);

	logic [sdrs_pkg::CYL_W-1:0] mem [MAX_REQ];

	logic [CW-1:0]                 count_q, ptr_q, k_q;
	logic                          vld_s1;
	logic [IW-1:0]                 idx_s1;
	logic [sdrs_pkg::CYL_W-1:0]    rdata_s1;
	logic                          best_vld_q, have_last_q, phase2_q, up_q;
	logic [sdrs_pkg::CYL_W-1:0]    best_v_q, last_v_q, start_q, head_q;
	logic [IW-1:0]                 best_i_q, last_i_q;
	logic [sdrs_pkg::TRAVEL_W-1:0] travel_q, travel_srv;
	logic                          strobe_q, out_last_q, out_empty_q;
	logic [sdrs_pkg::CYL_W-1:0]    out_cyl_q;
	logic [sdrs_pkg::SEEK_W-1:0]   out_seek_q;

	logic                          full, issue, asc, in_region, after_last, better, take;
	logic                          last_srv;
	logic [sdrs_pkg::CYL_W-1:0]    step_dist;

	assign full  = (count_q == MAX_CNT);
	assign issue = ctl.scan && (ptr_q != count_q);
	assign asc   = up_q ^ phase2_q;

	// sweep side of the current phase relative to the start position
	always_comb begin
		case ({up_q, phase2_q})
			2'b10:   in_region = rdata_s1 >= start_q;
			2'b11:   in_region = rdata_s1 <  start_q;
			2'b00:   in_region = rdata_s1 <= start_q;
			default: in_region = rdata_s1 >  start_q;
		endcase
	end

	// order is (value, index), value ascending or descending, index ascending
	assign after_last = !have_last_q
		|| (asc ? (rdata_s1 > last_v_q) : (rdata_s1 < last_v_q))
		|| ((rdata_s1 == last_v_q) && (idx_s1 > last_i_q));
	assign better = !best_vld_q || (asc ? (rdata_s1 < best_v_q) : (rdata_s1 > best_v_q));
	assign take   = vld_s1 && in_region && after_last && better;

	assign step_dist  = (best_v_q >= head_q) ? (best_v_q - head_q) : (head_q - best_v_q);
	assign travel_srv = travel_q + sdrs_pkg::TRAVEL_W'(step_dist);
	assign last_srv   = ((k_q + CW'(1)) == count_q);

	assign sts.count_zero = (count_q == '0);
	assign sts.scan_done  = (ptr_q == count_q) && !vld_s1;
	assign sts.found      = best_vld_q;
	assign sts.last       = last_srv;

	always_ff @(posedge clk) begin
		if (ctl.load && !full) begin
			mem[count_q[IW-1:0]] <= cylinder;
		end
		rdata_s1 <= mem[ptr_q[IW-1:0]];
		idx_s1   <= ptr_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			best_vld_q  <= 1'b0;
			have_last_q <= 1'b0;
			phase2_q    <= 1'b0;
			up_q        <= 1'b0;
			head_q      <= '0;
			travel_q    <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= ctl.serve || ctl.emit_empty;
			vld_s1   <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (take) begin
				best_vld_q <= 1'b1;
			end
			if (ctl.load && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (ctl.run_init) begin
				head_q      <= cylinder;
				up_q        <= direction;
				travel_q    <= '0;
				k_q         <= '0;
				phase2_q    <= 1'b0;
				have_last_q <= 1'b0;
				ptr_q       <= '0;
				best_vld_q  <= 1'b0;
			end
			if (ctl.serve) begin
				travel_q    <= travel_srv;
				head_q      <= best_v_q;
				have_last_q <= 1'b1;
				k_q         <= k_q + CW'(1);
				ptr_q       <= '0;
				best_vld_q  <= 1'b0;
				if (last_srv) begin
					count_q <= '0;
				end
			end
			if (ctl.edge_move) begin
				phase2_q    <= 1'b1;
				have_last_q <= 1'b0;
				ptr_q       <= '0;
				best_vld_q  <= 1'b0;
				if (up_q == sdrs_pkg::DIR_UP) begin
					if (max_cyl > head_q) begin
						travel_q <= travel_q + sdrs_pkg::TRAVEL_W'(max_cyl - head_q);
						head_q   <= max_cyl;
					end
				end else begin
					travel_q <= travel_q + sdrs_pkg::TRAVEL_W'(head_q);
					head_q   <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_v_q <= rdata_s1;
			best_i_q <= idx_s1;
		end
		if (ctl.run_init) begin
			start_q <= cylinder;
		end
		if (ctl.serve) begin
			last_v_q    <= best_v_q;
			last_i_q    <= best_i_q;
			out_cyl_q   <= best_v_q;
			out_seek_q  <= travel_srv[sdrs_pkg::SEEK_W-1:0];
			out_last_q  <= last_srv;
			out_empty_q <= 1'b0;
		end
		if (ctl.emit_empty) begin
			out_cyl_q   <= '0;
			out_seek_q  <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end
	end

	assign strobe          = strobe_q;
	assign served_cylinder = out_cyl_q;
	assign seek_total      = out_seek_q;
	assign last_of_run     = out_last_q;
	assign queue_empty     = out_empty_q;

endmodule
`default_nettype wire

>>> design/sdrs_ctrl.sv
`default_nettype none
module sdrs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           req_type,
	input  wire sdrs_pkg::sts_t sts,
	output sdrs_pkg::ctl_t      ctl,
	output logic                busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_PICK  = 4'b0100,
		ST_EMPTY = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == sdrs_pkg::REQ_RUN) begin
						ctl.run_init = 1'b1;
						state_nxt    = sts.count_zero ? ST_EMPTY : ST_SCAN;
					end else begin
						ctl.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_PICK;
				end
			end
			ST_PICK: begin
				if (sts.found) begin
					ctl.serve = 1'b1;
					state_nxt = sts.last ? ST_IDLE : ST_SCAN;
				end else begin
					// nothing left on the first side: go to the edge and turn
					ctl.edge_move = 1'b1;
					state_nxt     = ST_SCAN;
				end
			end
			ST_EMPTY: begin
				ctl.emit_empty = 1'b1;
				state_nxt      = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

>>> design/scan_disk_request_scheduler_unit.sv
// Load beat: one per cycle while idle. A run with N stored requests emits N results;
// each comes from a scan with one store read per entry through the single read port,
// a read stage and a compare stage, then a pick state, plus another scan at the reversal.
// Empty run: one result via the empty state. Results are strobed one cycle each.
// Reset (arst_n low) empties the store, sets max_cylinder to 65535, returns to idle.
`default_nettype none
`include "scan_disk_request_scheduler_unit_assert.svh"
module scan_disk_request_scheduler_unit #(
	parameter int MAX_REQ = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          req_type,
	input  wire logic [sdrs_pkg::CYL_W-1:0]    cylinder,
	input  wire logic                          direction,
	output logic                               strobe,
	output logic      [sdrs_pkg::CYL_W-1:0]    served_cylinder,
	output logic      [sdrs_pkg::SEEK_W-1:0]   seek_total,
	output logic                               last_of_run,
	output logic                               queue_empty,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sdrs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [sdrs_pkg::PDATA_W-1:0]  pwdata,
	output logic      [sdrs_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	sdrs_pkg::ctl_t             ctl;
	sdrs_pkg::sts_t             sts;
	logic [sdrs_pkg::CYL_W-1:0] max_cyl;

	sdrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_cyl (max_cyl)
	);

	sdrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.ctl      (ctl),
		.busy     (busy)
	);

	sdrs_dp #(
		.MAX_REQ (MAX_REQ)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cylinder        (cylinder),
		.direction       (direction),
		.max_cyl         (max_cyl),
		.strobe          (strobe),
		.served_cylinder (served_cylinder),
		.seek_total      (seek_total),
		.last_of_run     (last_of_run),
		.queue_empty     (queue_empty)
	);

	`SDRS_ASSERT_IMP(a_empty_is_last, clk, arst_n, strobe && queue_empty, last_of_run)
	`SDRS_ASSERT_IMP(a_last_frees, clk, arst_n, strobe && last_of_run, !busy)
	`SDRS_ASSERT_NXT(a_run_goes_busy, clk, arst_n, start && !busy && req_type, busy)
	`SDRS_ASSERT_NXT(a_load_no_result, clk, arst_n, start && !busy && !req_type, !strobe)

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sdrs_pkg::*;

	localparam int STORE_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 96;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [CYL_W-1:0]  cyl;
		logic [SEEK_W-1:0] seek;
		logic              last;
		logic              empty;
	} serve_t;

	// Elevator-order predictor plus the queue of serve beats still owed by the block.
	class scan_order_board;
		logic [CYL_W-1:0]    store [STORE_DEPTH];
		bit                  done [STORE_DEPTH];
		int                  count = 0;
		int                  run_served = 0;
		logic [CYL_W-1:0]    head = '0;
		logic [TRAVEL_W-1:0] travel = '0;
		logic [CYL_W-1:0]    max_cyl = MAX_CYL_RESET;
		serve_t              owed_serves[$];
		int                  errors = 0;
		int                  checked = 0;
		int                  loads = 0;
		int                  runs = 0;
		int                  empty_runs = 0;

		// ascend: lowest unserved value >= lim; otherwise highest unserved value <= lim
		function int pick(bit ascend, int unsigned lim);
			int best = -1;
			for (int i = 0; i < count; i++) begin
				if (!done[i]) begin
					if (ascend && store[i] >= lim && (best < 0 || store[i] < store[best]))
						best = i;
					if (!ascend && store[i] <= lim && (best < 0 || store[i] > store[best]))
						best = i;
				end
			end
			return best;
		endfunction

		function void serve_at(int idx);
			int unsigned v;
			int unsigned d;
			serve_t s;
			v = store[idx];
			d = (v >= head) ? v - head : head - v;
			done[idx] = 1'b1;
			travel = travel + d;
			head = v;
			run_served++;
			s.cyl = v[CYL_W-1:0];
			s.seek = travel[SEEK_W-1:0];
			s.last = (run_served == count);
			s.empty = 1'b0;
			owed_serves.push_back(s);
		endfunction

		function void note_beat(logic typ, logic [CYL_W-1:0] cyl, logic dir);
			int idx;
			serve_t s;
			if (typ == REQ_LOAD) begin
				loads++;
				// full store drops the load
				if (count < STORE_DEPTH) begin
					store[count] = cyl;
					done[count] = 1'b0;
					count++;
				end
				return;
			end
			runs++;
			head = cyl;
			travel = '0;
			run_served = 0;
			foreach (done[i]) done[i] = 1'b0;
			if (count == 0) begin
				empty_runs++;
				s.cyl = '0;
				s.seek = '0;
				s.last = 1'b1;
				s.empty = 1'b1;
				owed_serves.push_back(s);
				return;
			end
			if (dir == DIR_UP) begin
				idx = pick(1'b1, head);
				while (idx >= 0) begin
					serve_at(idx);
					idx = pick(1'b1, head);
				end
				if (run_served < count) begin
					// sweep out to the rim unless the rim lies below the head
					if (max_cyl > head) begin
						travel = travel + (max_cyl - head);
						head = max_cyl;
					end
					idx = pick(1'b0, 16'hFFFF);
					while (idx >= 0) begin
						serve_at(idx);
						idx = pick(1'b0, 16'hFFFF);
					end
				end
			end else begin
				idx = pick(1'b0, head);
				while (idx >= 0) begin
					serve_at(idx);
					idx = pick(1'b0, head);
				end
				if (run_served < count) begin
					travel = travel + head;
					head = '0;
					idx = pick(1'b1, 0);
					while (idx >= 0) begin
						serve_at(idx);
						idx = pick(1'b1, 0);
					end
				end
			end
			count = 0;
			foreach (done[i]) done[i] = 1'b0;
		endfunction

		function void compare(string fname, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 30)
					$display("%0t: %s mismatch: expected %0d, actual %0d",
						$time, fname, want, got);
			end
		endfunction

		function void check_served(logic [CYL_W-1:0] cyl, logic [SEEK_W-1:0] seek,
				logic last, logic empty);
			serve_t want;
			checked++;
			if (owed_serves.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%0t: unexpected beat: expected none, actual cylinder %0d seek %0d",
						$time, cyl, seek);
				return;
			end
			want = owed_serves.pop_front();
			compare("served_cylinder", want.cyl, cyl);
			compare("seek_total", want.seek, seek);
			compare("last_of_run", want.last, last);
			compare("queue_empty", want.empty, empty);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                req_type = REQ_LOAD;
	logic [CYL_W-1:0]    cylinder = '0;
	logic                direction = DIR_DOWN;
	logic                strobe;
	logic [CYL_W-1:0]    served_cylinder;
	logic [SEEK_W-1:0]   seek_total;
	logic                last_of_run;
	logic                queue_empty;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	scan_order_board board = new;
	int cycle_count = 0;
	int reg_writes = 0;

	scan_disk_request_scheduler_unit #(.MAX_REQ(STORE_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.cylinder(cylinder),
		.direction(direction),
		.strobe(strobe),
		.served_cylinder(served_cylinder),
		.seek_total(seek_total),
		.last_of_run(last_of_run),
		.queue_empty(queue_empty),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_served(served_cylinder, seek_total, last_of_run, queue_empty);
	end

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic [CYL_W-1:0] pick_cylinder(int mode, logic [CYL_W-1:0] base);
		case (mode)
			0: return base + CYL_W'($urandom_range(0, 15));
			1: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return CYL_W'($urandom_range(0, 65535));
				endcase
			end
			default: return CYL_W'($urandom());
		endcase
	endfunction

	// start stays high across back-to-back beats; it drops only when a gap follows
	task automatic send_beat(logic typ, logic [CYL_W-1:0] cyl, logic dir, int gap_after);
		start <= 1'b1;
		req_type <= typ;
		cylinder <= cyl;
		direction <= dir;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_beat(typ, cyl, dir);
		if (gap_after > 0) begin
			start <= 1'b0;
			repeat (gap_after) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.owed_serves.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_max_cyl(logic [CYL_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MAX_CYL, 2'b00};
		pwdata <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.max_cyl = val;
		reg_writes++;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d serve beats still owed",
			cycle_count, board.owed_serves.size());
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int n;
		int seq;
		int rand_items;
		int mode;
		bit burst;
		logic [CYL_W-1:0] base;
		logic [CYL_W-1:0] last_load;
		logic [CYL_W-1:0] run_head;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// runs on an empty store, both directions
		send_beat(REQ_RUN, 16'd1234, DIR_UP, draw_gap(1'b0));
		send_beat(REQ_RUN, 16'hFFFF, DIR_DOWN, draw_gap(1'b0));
		// duplicates, request at the head, both field extremes
		send_beat(REQ_LOAD, 16'd100, DIR_UP, 0);
		send_beat(REQ_LOAD, 16'd100, DIR_DOWN, 0);
		send_beat(REQ_LOAD, 16'd0, DIR_UP, draw_gap(1'b0));
		send_beat(REQ_LOAD, 16'hFFFF, DIR_UP, 0);
		send_beat(REQ_LOAD, 16'd500, DIR_DOWN, draw_gap(1'b0));
		send_beat(REQ_RUN, 16'd100, DIR_UP, draw_gap(1'b0));
		// upward sweep that travels to the rim before reversing
		send_beat(REQ_LOAD, 16'd9000, DIR_DOWN, 0);
		send_beat(REQ_LOAD, 16'd7, DIR_UP, 0);
		send_beat(REQ_RUN, 16'd8000, DIR_UP, draw_gap(1'b0));

		drain();
		write_max_cyl('0);
		// rim below the head: reverse in place
		send_beat(REQ_LOAD, 16'd300, DIR_UP, draw_gap(1'b0));
		send_beat(REQ_LOAD, 16'd50, DIR_DOWN, 0);
		send_beat(REQ_LOAD, 16'd700, DIR_UP, 0);
		send_beat(REQ_RUN, 16'd200, DIR_UP, draw_gap(1'b0));
		// downward sweep to cylinder 0, nothing below the head
		send_beat(REQ_LOAD, 16'd10, DIR_UP, 0);
		send_beat(REQ_LOAD, 16'd20, DIR_DOWN, 0);
		send_beat(REQ_RUN, 16'd5, DIR_DOWN, draw_gap(1'b0));
		// nothing behind the head, both directions
		send_beat(REQ_LOAD, 16'd40, DIR_DOWN, 0);
		send_beat(REQ_LOAD, 16'd30, DIR_UP, 0);
		send_beat(REQ_RUN, 16'd50, DIR_DOWN, draw_gap(1'b0));
		send_beat(REQ_LOAD, 16'd200, DIR_DOWN, 0);
		send_beat(REQ_LOAD, 16'd300, DIR_UP, 0);
		send_beat(REQ_RUN, 16'd100, DIR_UP, draw_gap(1'b0));

		seq = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (seq % 3 == 0) begin
				drain();
				if (seq == 0)
					write_max_cyl('1);
				else begin
					case ($urandom_range(0, 3))
						0: write_max_cyl('0);
						1: write_max_cyl('1);
						2: write_max_cyl(CYL_W'($urandom_range(0, 2000)));
						default: write_max_cyl(CYL_W'($urandom()));
					endcase
				end
			end
			// one pass overfills the store so that loads get dropped
			if (seq == 1)
				n = STORE_DEPTH + 4;
			else begin
				case ($urandom_range(0, 19))
					0, 1: n = 0;
					2: n = $urandom_range(30, STORE_DEPTH);
					default: n = $urandom_range(1, 12);
				endcase
			end
			mode = $urandom_range(0, 3);
			base = CYL_W'($urandom());
			burst = ($urandom_range(0, 3) == 0);
			last_load = '0;
			for (int i = 0; i < n; i++) begin
				last_load = pick_cylinder(mode, base);
				send_beat(REQ_LOAD, last_load, 1'($urandom_range(0, 1)), draw_gap(burst));
			end
			if (n > 0 && $urandom_range(0, 2) == 0)
				run_head = last_load;
			else
				run_head = pick_cylinder(mode, base);
			send_beat(REQ_RUN, run_head, 1'($urandom_range(0, 1)), draw_gap(burst));
			rand_items += n + 1;
			seq++;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d loads and %0d runs (%0d on an empty store) over %0d max_cylinder settings",
			board.loads, board.runs, board.empty_runs, reg_writes + 1);
		$display("%0d serve beats checked, %0d mismatches", board.checked, board.errors);
		if (board.errors == 0 && board.owed_serves.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
